>>> hw/rtl/sar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sar_pkg
// Shared widths, reset values and the controller-to-datapath command word
// for the alternate-block string reverser.
// ----------------------------------------------------------------------------
package sar_pkg;

	localparam int BYTE_W        = 8;
	localparam int BLOCK_LEN_W   = 7;
	localparam int MAX_BLOCK_DEF = 64;

	localparam logic [BLOCK_LEN_W-1:0] BLOCK_LEN_RST = 7'd1;

	// one command per cycle from the controller
	typedef struct packed {
		logic push;         // write incoming byte to the stack
		logic rd_en;        // launch a stack read
		logic load;         // load the output register
		logic sel_mem;      // 1: stack read data, 0: incoming byte
		logic run_end;
		logic string_done;
	} sar_cmd_t;

	typedef struct packed {
		logic out_free;     // output register empty or being taken
	} sar_stat_t;

endpackage

>>> hw/rtl/sar_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sar_if
// Valid/ready channels: incoming string bytes and outgoing result words.
// ----------------------------------------------------------------------------
interface sar_in_if;
	logic                       valid;
	logic                       ready;
	logic [sar_pkg::BYTE_W-1:0] byte_in;
	logic                       string_end;

	modport source (output valid, output byte_in, output string_end, input ready);
	modport sink   (input valid, input byte_in, input string_end, output ready);
endinterface

interface sar_out_if;
	logic                       valid;
	logic                       ready;
	logic [sar_pkg::BYTE_W-1:0] byte_out;
	logic                       run_end;
	logic                       string_done;

	modport source (output valid, output byte_out, output run_end, output string_done,
		input ready);
	modport sink   (input valid, input byte_out, input run_end, input string_done,
		output ready);
endinterface

>>> hw/rtl/segment_alternate_reverser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_alternate_reverser
// Alternate-block byte string reverser. Bytes arrive one word at a time with
// string_end on the last byte of a string. From each string start, the first
// block_len bytes of every 2*block_len window come out reversed and the next
// block_len pass unchanged; a string ending mid-block flushes the partial
// block reversed, and the next string starts afresh. block_len (cfg_wdata,
// 7 bits, reset 1) reads 0 as 1 and saturates at MAX_BLOCK; write it only
// while the block is idle. A byte that completes a reversed block of n bytes
// goes straight from the input into the output register, and the other n-1
// follow one per cycle from the stack's single read port while the output
// register is free, the input being held meanwhile. Result words sit in one
// output register, so a stalled sink stops the block only once that register
// is full.
// ----------------------------------------------------------------------------
module segment_alternate_reverser #(
	parameter int MAX_BLOCK = sar_pkg::MAX_BLOCK_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sar_pkg::BLOCK_LEN_W-1:0] cfg_wdata,
	sar_in_if.sink                          upstream,
	sar_out_if.source                       downstream
);

	localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

	sar_pkg::sar_cmd_t  cmd;
	sar_pkg::sar_stat_t stat;
	logic [AW-1:0]      wr_addr;
	logic [AW-1:0]      rd_addr;
	logic               in_ready;

	assign upstream.ready = in_ready;

	// counters, phase tracking and the reversed-block drain sequence
	sar_ctrl #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (upstream.valid),
		.in_last   (upstream.string_end),
		.in_ready  (in_ready),
		.stat      (stat),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr)
	);

	// stack memory and output word register
	sar_dp #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.byte_in (upstream.byte_in),
		.stat    (stat),
		.down    (downstream)
	);

endmodule

>>> hw/rtl/sar_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sar_dp
// Datapath: byte stack memory with registered read, and output register.
// ----------------------------------------------------------------------------
module sar_dp #(
	parameter int MAX_BLOCK = sar_pkg::MAX_BLOCK_DEF,
	localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sar_pkg::sar_cmd_t          cmd,
	input  logic [AW-1:0]              wr_addr,
	input  logic [AW-1:0]              rd_addr,
	input  logic [sar_pkg::BYTE_W-1:0] byte_in,
	output sar_pkg::sar_stat_t         stat,
	sar_out_if.source                  down
);

	logic [sar_pkg::BYTE_W-1:0] stack_mem [MAX_BLOCK];
	logic [sar_pkg::BYTE_W-1:0] rd_data_q;
	logic [sar_pkg::BYTE_W-1:0] byte_q;
	logic                       run_end_q;
	logic                       done_q;
	logic                       valid_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stack_mem[wr_addr] <= byte_in;
		end
		if (cmd.rd_en) begin
			rd_data_q <= stack_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q    <= cmd.sel_mem ? rd_data_q : byte_in;
			run_end_q <= cmd.run_end;
			done_q    <= cmd.string_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.load) begin
			valid_q <= 1'b1;
		end else if (down.ready) begin
			valid_q <= 1'b0;
		end
	end

	assign stat.out_free    = !valid_q || down.ready;
	assign down.valid       = valid_q;
	assign down.byte_out    = byte_q;
	assign down.run_end     = run_end_q;
	assign down.string_done = done_q;

endmodule

>>> hw/rtl/sar_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sar_ctrl
// Controller: phase and fill counters, block length register, drain sequencer.
// ----------------------------------------------------------------------------
module sar_ctrl #(
	parameter int MAX_BLOCK = sar_pkg::MAX_BLOCK_DEF,
	localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1,
	localparam int CW = $clog2(MAX_BLOCK + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sar_pkg::BLOCK_LEN_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	input  logic                            in_last,
	output logic                            in_ready,
	input  sar_pkg::sar_stat_t              stat,
	output sar_pkg::sar_cmd_t               cmd,
	output logic [AW-1:0]                   wr_addr,
	output logic [AW-1:0]                   rd_addr
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic                            state_q;
	logic [sar_pkg::BLOCK_LEN_W-1:0] block_len_q;
	logic [sar_pkg::BLOCK_LEN_W-1:0] eff_len;
	logic [CW-1:0]                   fill_q;
	logic [CW-1:0]                   pass_q;
	logic                            phase_q;    // 0 reverse, 1 pass
	logic [AW-1:0]                   idx_q;      // stack entry in rd_data
	logic                            last_q;
	logic [CW-1:0]                   fill_inc;
	logic [CW-1:0]                   pass_inc;
	logic                            accept;
	logic                            flush;
	logic                            pass_end;

	always_comb begin
		if (block_len_q == '0) begin
			eff_len = sar_pkg::BLOCK_LEN_W'(1);
		end else if (block_len_q > sar_pkg::BLOCK_LEN_W'(MAX_BLOCK)) begin
			eff_len = sar_pkg::BLOCK_LEN_W'(MAX_BLOCK);
		end else begin
			eff_len = block_len_q;
		end
	end

	assign fill_inc = fill_q + 1'b1;
	assign pass_inc = pass_q + 1'b1;
	assign in_ready = (state_q == ST_IDLE) && stat.out_free;
	assign accept   = in_valid && in_ready;
	assign flush    = !phase_q && ((sar_pkg::BLOCK_LEN_W'(fill_inc) >= eff_len) || in_last);
	assign pass_end = phase_q && ((sar_pkg::BLOCK_LEN_W'(pass_inc) >= eff_len) || in_last);
	assign wr_addr  = AW'(fill_q);
	assign rd_addr  = (state_q == ST_IDLE) ? AW'(fill_q - 1'b1) : (idx_q - 1'b1);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!phase_q) begin
						cmd.push = 1'b1;
						if (flush) begin
							// newest byte leaves first, straight from the input
							cmd.load        = 1'b1;
							cmd.run_end     = (fill_q == '0);
							cmd.string_done = (fill_q == '0) && in_last;
							cmd.rd_en       = (fill_q != '0);
						end
					end else begin
						cmd.load        = 1'b1;
						cmd.run_end     = 1'b1;
						cmd.string_done = in_last;
					end
				end
			end
			ST_DRAIN: begin
				if (stat.out_free) begin
					cmd.load        = 1'b1;
					cmd.sel_mem     = 1'b1;
					cmd.run_end     = (idx_q == '0);
					cmd.string_done = (idx_q == '0) && last_q;
					cmd.rd_en       = (idx_q != '0);
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_len_q <= sar_pkg::BLOCK_LEN_RST;
		end else if (cfg_we) begin
			block_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			pass_q  <= '0;
			phase_q <= 1'b0;
			idx_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!phase_q) begin
							if (flush) begin
								fill_q  <= '0;
								pass_q  <= '0;
								phase_q <= !in_last;
								last_q  <= in_last;
								if (fill_q != '0) begin
									idx_q   <= AW'(fill_q - 1'b1);
									state_q <= ST_DRAIN;
								end
							end else begin
								fill_q <= fill_inc;
							end
						end else if (pass_end) begin
							phase_q <= 1'b0;
							pass_q  <= '0;
						end else begin
							pass_q <= pass_inc;
						end
					end
				end
				ST_DRAIN: begin
					if (stat.out_free) begin
						if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
